// ----- design/top_k_smallest_max_heap_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the top-k max-heap unit
// Clocked concurrent checks; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SMALLEST_MAX_HEAP_UNIT_DEFINES_SVH
`define TOP_K_SMALLEST_MAX_HEAP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check outside reset
`define TKSMH_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tksmh check failed");
// check that also holds while reset is applied
`define TKSMH_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tksmh check failed");
`else
`define TKSMH_ASSERT(label, prop)
`define TKSMH_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- design/tksmh_pkg.sv -----
// ----------------------------------------------------------------------------
// tksmh_pkg
// Shared types and constants of the top-k max-heap unit.
// ----------------------------------------------------------------------------
package tksmh_pkg;

    localparam int HEAP_CAPACITY = 256;
    localparam int ADDR_W        = $clog2(HEAP_CAPACITY);
    localparam int IDX_W         = ADDR_W + 2;
    localparam int CNT_W         = 9;
    localparam int K_W           = 9;
    localparam int KEY_W         = 32;
    localparam int ID_W          = 32;
    localparam int RANK_W        = 8;

    localparam logic [K_W-1:0] ACTIVE_K_RESET = K_W'(200);

    // commands
    localparam logic [1:0] CMD_OFFER = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // outcomes
    localparam logic [2:0] OUT_INSERTED  = 3'd0;
    localparam logic [2:0] OUT_REPLACED  = 3'd1;
    localparam logic [2:0] OUT_REJECTED  = 3'd2;
    localparam logic [2:0] OUT_POPPED    = 3'd3;
    localparam logic [2:0] OUT_POP_EMPTY = 3'd4;
    localparam logic [2:0] OUT_CLEARED   = 3'd5;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] dist_key;
        logic [ID_W-1:0]  point_id;
    } cmd_word_t;

    typedef struct packed {
        logic [2:0]        outcome;
        logic [KEY_W-1:0]  popped_key;
        logic [ID_W-1:0]   popped_id;
        logic [RANK_W-1:0] ascending_rank;
        logic [CNT_W-1:0]  kept_count;
        logic              is_full;
        logic [KEY_W-1:0]  worst_key;
    } res_word_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } entry_t;

    // one cycle of heap memory traffic
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic [ADDR_W-1:0] ra_addr;
        logic [ADDR_W-1:0] rb_addr;
    } mem_req_t;

endpackage

// ----- design/tksmh_heap_ram.sv -----
// ----------------------------------------------------------------------------
// tksmh_heap_ram
// Heap entry store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module tksmh_heap_ram (
    input  logic              clk,
    input  tksmh_pkg::mem_req_t req,
    output tksmh_pkg::entry_t rd_a,
    output tksmh_pkg::entry_t rd_b
);
    import tksmh_pkg::*;

    entry_t heap_mem [HEAP_CAPACITY];
    entry_t rd_a_reg;
    entry_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            heap_mem[req.waddr] <= req.wdata;
        end
        rd_a_reg <= heap_mem[req.ra_addr];
        rd_b_reg <= heap_mem[req.rb_addr];
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

// ----- design/tksmh_ctrl.sv -----
// ----------------------------------------------------------------------------
// tksmh_ctrl
// Heap sequencer: insert / replace / pop / clear with hole-based sifting.
// ----------------------------------------------------------------------------
module tksmh_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  tksmh_pkg::cmd_word_t      cmd,
    input  logic [tksmh_pkg::K_W-1:0] k_eff,
    input  logic                      res_take,
    input  tksmh_pkg::entry_t         rd_a,
    input  tksmh_pkg::entry_t         rd_b,
    output tksmh_pkg::mem_req_t       req,
    output logic                      busy,
    output logic                      done,
    output tksmh_pkg::res_word_t      res
);
    import tksmh_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UP     = 3'd1; // parent data arriving
    localparam logic [2:0] ST_DN     = 3'd2; // child data arriving
    localparam logic [2:0] ST_LAST   = 3'd3; // last entry arriving (pop)
    localparam logic [2:0] ST_PLACE  = 3'd4; // drop item into the hole
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]        state_reg,   state_next;
    logic [ADDR_W-1:0] pos_reg,     pos_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    entry_t            item_reg,    item_next;
    entry_t            popped_reg,  popped_next;
    logic [2:0]        outcome_reg, outcome_next;
    entry_t            root_reg;

    logic [IDX_W-1:0]  n_w;
    logic [IDX_W-1:0]  l_w, r_w;
    logic              l_ok, r_ok;
    logic              take_l, take_r;
    logic [KEY_W-1:0]  big_key;
    logic [ADDR_W-1:0] big_pos;
    logic [IDX_W-1:0]  nl_w;
    logic [ADDR_W-1:0] par_pos;
    logic [ADDR_W-1:0] gpar_pos;
    logic [ADDR_W-1:0] cnt_par;

    assign n_w  = IDX_W'(count_reg);
    assign l_w  = {1'b0, pos_reg, 1'b1};
    assign r_w  = l_w + IDX_W'(1);
    assign l_ok = l_w < n_w;
    assign r_ok = r_w < n_w;

    // pick the larger child; left wins a tie
    always_comb
    begin
        take_l  = l_ok && (rd_a.key > item_reg.key);
        big_key = take_l ? rd_a.key : item_reg.key;
        take_r  = r_ok && (rd_b.key > big_key);
    end

    assign big_pos  = take_r ? r_w[ADDR_W-1:0] : l_w[ADDR_W-1:0];
    assign nl_w     = {1'b0, big_pos, 1'b1};
    assign par_pos  = (pos_reg - ADDR_W'(1)) >> 1;
    assign gpar_pos = (par_pos - ADDR_W'(1)) >> 1;
    assign cnt_par  = ADDR_W'((count_reg - CNT_W'(1)) >> 1);

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        item_next    = item_reg;
        popped_next  = popped_reg;
        outcome_next = outcome_reg;
        req.we       = 1'b0;
        req.waddr    = pos_reg;
        req.wdata    = item_reg;
        req.ra_addr  = '0;
        req.rb_addr  = '0;
        done         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    popped_next = '0;
                    unique case (cmd.command)
                        CMD_OFFER:
                        begin
                            item_next = '{key: cmd.dist_key, id: cmd.point_id};
                            if (count_reg < k_eff)
                            begin
                                outcome_next = OUT_INSERTED;
                                pos_next     = count_reg[ADDR_W-1:0];
                                count_next   = count_reg + CNT_W'(1);
                                if (count_reg == '0)
                                begin
                                    req.we      = 1'b1;
                                    req.waddr   = '0;
                                    req.wdata   = item_next;
                                    state_next  = ST_FINISH;
                                end
                                else
                                begin
                                    req.ra_addr = cnt_par;
                                    state_next  = ST_UP;
                                end
                            end
                            else if (cmd.dist_key < root_reg.key)
                            begin
                                outcome_next = OUT_REPLACED;
                                pos_next     = '0;
                                if (count_reg > CNT_W'(1))
                                begin
                                    req.ra_addr = ADDR_W'(1);
                                    req.rb_addr = ADDR_W'(2);
                                    state_next  = ST_DN;
                                end
                                else
                                begin
                                    req.we     = 1'b1;
                                    req.waddr  = '0;
                                    req.wdata  = item_next;
                                    state_next = ST_FINISH;
                                end
                            end
                            else
                            begin
                                outcome_next = OUT_REJECTED;
                                state_next   = ST_FINISH;
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                outcome_next = OUT_POP_EMPTY;
                                state_next   = ST_FINISH;
                            end
                            else
                            begin
                                outcome_next = OUT_POPPED;
                                popped_next  = root_reg;
                                count_next   = count_reg - CNT_W'(1);
                                req.ra_addr  = count_next[ADDR_W-1:0];
                                state_next   = ST_LAST;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            outcome_next = OUT_CLEARED;
                            count_next   = '0;
                            state_next   = ST_FINISH;
                        end
                        CMD_NOP:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_UP:
            begin
                req.we = 1'b1;
                if (item_reg.key > rd_a.key)
                begin
                    req.wdata = rd_a;
                    pos_next  = par_pos;
                    if (par_pos == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        req.ra_addr = gpar_pos;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_DN:
            begin
                req.we = 1'b1;
                if (take_l || take_r)
                begin
                    req.wdata = take_r ? rd_b : rd_a;
                    pos_next  = big_pos;
                    if (nl_w < n_w)
                    begin
                        req.ra_addr = nl_w[ADDR_W-1:0];
                        req.rb_addr = ADDR_W'(nl_w + IDX_W'(1));
                    end
                    else
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_LAST:
            begin
                item_next = rd_a;
                pos_next  = '0;
                if (count_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (count_reg > CNT_W'(1))
                begin
                    req.ra_addr = ADDR_W'(1);
                    req.rb_addr = ADDR_W'(2);
                    state_next  = ST_DN;
                end
                else
                begin
                    req.we     = 1'b1;
                    req.waddr  = '0;
                    req.wdata  = rd_a;
                    state_next = ST_FINISH;
                end
            end

            ST_PLACE:
            begin
                req.we     = 1'b1;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (res_take)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // root shadow copy tracks every write of entry 0
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        item_reg    <= item_next;
        popped_reg  <= popped_next;
        outcome_reg <= outcome_next;
        if (req.we && (req.waddr == '0))
        begin
            root_reg <= req.wdata;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        res.outcome        = outcome_reg;
        res.popped_key     = popped_reg.key;
        res.popped_id      = popped_reg.id;
        res.ascending_rank = (outcome_reg == OUT_POPPED) ? count_reg[RANK_W-1:0] : '0;
        res.kept_count     = count_reg;
        res.is_full        = (count_reg >= k_eff);
        res.worst_key      = (count_reg != '0) ? root_reg.key : '0;
    end

endmodule

// ----- design/top_k_smallest_max_heap_unit.sv -----
// ----------------------------------------------------------------------------
// top_k_smallest_max_heap_unit
// Keeps the active_k smallest-key (key, id) candidates in a binary max-heap.
// ----------------------------------------------------------------------------
// One word in, one result word out (an unused command code gives no result).
// Items are handled one at a time. An offer that inserts lets the new entry
// climb from the end of the heap; a replace or a pop sinks a hole from the
// root. The sift loop handles each level with one access of the heap memory,
// which reads both children (or the parent) while writing the entry moved
// into the hole. The result register frees the controller, so the next
// command is taken as soon as the current result is parked, even while that
// result is stalled. worst_key comes from a shadow copy of the root, so
// pruning needs no read. The heap memory needs no clearing after reset: only
// entries below the count are ever used. active_k is saturated to 1..256 and
// may only be written while the unit is idle.
`include "top_k_smallest_max_heap_unit_defines.svh"

module top_k_smallest_max_heap_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  tksmh_pkg::cmd_word_t      cmd_word,
    output logic                      res_valid,
    input  logic                      res_stall,
    output tksmh_pkg::res_word_t      res_word,
    input  logic                      cfg_wr_en,
    input  logic [tksmh_pkg::K_W-1:0] cfg_wr_data
);
    import tksmh_pkg::*;

    logic [K_W-1:0] active_k_reg;
    logic [K_W-1:0] k_eff;
    logic           start;
    logic           busy;
    logic           done;
    logic           res_take;
    res_word_t      res_next;
    res_word_t      res_word_reg;
    logic           res_valid_reg;
    mem_req_t       req;
    entry_t         rd_a;
    entry_t         rd_b;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_k_reg <= ACTIVE_K_RESET;
        end
        else if (cfg_wr_en)
        begin
            active_k_reg <= cfg_wr_data;
        end
    end

    // saturate K into 1..capacity
    always_comb
    begin
        priority if (active_k_reg == '0)
        begin
            k_eff = K_W'(1);
        end
        else if (active_k_reg > K_W'(HEAP_CAPACITY))
        begin
            k_eff = K_W'(HEAP_CAPACITY);
        end
        else
        begin
            k_eff = active_k_reg;
        end
    end

    // input side: one word in flight in the sequencer
    assign cmd_stall = busy;
    assign start     = cmd_valid && !cmd_stall;

    // output register: sequencer may park a result whenever the slot drains
    assign res_take = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            res_word_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    tksmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd_word),
        .k_eff    (k_eff),
        .res_take (res_take),
        .rd_a     (rd_a),
        .rd_b     (rd_b),
        .req      (req),
        .busy     (busy),
        .done     (done),
        .res      (res_next)
    );

    tksmh_heap_ram u_heap_ram (
        .clk  (clk),
        .req  (req),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    // a real command makes the sequencer busy in the cycle after it is taken
    `TKSMH_ASSERT(a_cmd_busy, (start && (cmd_word.command != CMD_NOP)) |=> cmd_stall)
    // popped fields and rank are zero for every non-pop outcome
    `TKSMH_ASSERT(a_pop_fields, (res_valid && (res_word.outcome != OUT_POPPED)) |-> ((res_word.popped_key == '0) && (res_word.popped_id == '0) && (res_word.ascending_rank == '0)))
    // count never exceeds the heap capacity
    `TKSMH_ASSERT(a_count_cap, res_valid |-> (res_word.kept_count <= CNT_W'(HEAP_CAPACITY)))
    // no result shows up on the edge after reset is seen
    `TKSMH_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !res_valid)

endmodule
